FILE: rtl/saturating_3x3_sharpen_stencil_core_macros.svh
// Assertion macros shared by the sharpen stencil checker.
// Relies on a clock named clk and an active-low reset named arst_n in scope.
`ifndef SATURATING_3X3_SHARPEN_STENCIL_CORE_MACROS_SVH
`define SATURATING_3X3_SHARPEN_STENCIL_CORE_MACROS_SVH

// Check that a stalled beat holds its contents until taken
`define SSS_ASSERT_HOLD(lbl, vld, rdy, dat) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
		else $error("stalled beat changed before it was taken");

// Check that a condition always implies another
`define SSS_ASSERT_IMPLIES(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |-> (conseq)) \
		else $error("implication violated on output channel");

`endif

FILE: rtl/sss_pkg.sv
// Package for the saturating 3x3 sharpen stencil: sizes, register codes,
// pipeline payload types and the saturating sharpen step. No dependencies.
`default_nettype none
package sss_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int WID_W      = 12;
	localparam int HGT_W      = 13;
	localparam int CFG_W      = 13;
	localparam int LB_W       = 2 * PIX_W;

	localparam logic [WID_W-1:0] RST_WIDTH  = WID_W'(640);
	localparam logic [HGT_W-1:0] RST_HEIGHT = HGT_W'(480);
	localparam logic [WID_W-1:0] EFF_W_MAX  = WID_W'(MAX_WIDTH);
	localparam logic [HGT_W-1:0] EFF_H_MAX  = HGT_W'(MAX_HEIGHT);

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// Metadata carried alongside a pixel
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} meta_t;

	// Second half of the sharpen chain
	typedef struct packed {
		pix_t  v;
		pix_t  ctr;
		pix_t  nb_r;
		pix_t  nb_bl;
		pix_t  nb_b;
		pix_t  nb_br;
		meta_t meta;
	} s2_t;

	// One saturating subtract step, optionally followed by a saturating add-back
	function automatic pix_t sharp_step(input pix_t v, input pix_t nb, input pix_t ctr,
		input logic add_back);
		pix_t         d;
		logic [PIX_W:0] s;
		pix_t         res;
		d = (v > nb) ? pix_t'(v - nb) : '0;
		s = {1'b0, d} + {1'b0, ctr};
		if (!add_back) begin
			res = d;
		end else if (s[PIX_W]) begin
			res = '1;
		end else begin
			res = s[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module sss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/saturating_3x3_sharpen_stencil_core.sv
// A result passes through stage 1 (line-buffer read and first half of the chain),
// stage 2 (second half of the chain) and the output register.
// Throughput: one pixel per clock while the output is not stalled, set by the line-buffer
// RAM doing one read and one write per cycle. Reset: counters and window clear, width
// 640, height 480; the line buffers are not cleared and no clearing pass runs.
`default_nettype none
module saturating_3x3_sharpen_stencil_core (
	input  wire        clk,
	input  wire        arst_n,
	// config write port
	input  wire        cfg_wen,
	input  wire [0:0]  cfg_addr,
	input  wire [12:0] cfg_wdata,
	// input stream
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [7:0]  s_axis_tdata,   // [7:0] pixel_in
	// output stream
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] pixel_out, [19:8] out_row, [30:20] out_col, [31] zero
	output logic       m_axis_tlast    // frame_last
);

	localparam int PW = sss_pkg::PIX_W;
	localparam int CW = sss_pkg::COL_W;
	localparam int RW = sss_pkg::ROW_W;
	localparam int WW = sss_pkg::WID_W;
	localparam int HW = sss_pkg::HGT_W;

	// Configuration and counters
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;
	logic [WW-1:0] col_nxt;
	logic [HW-1:0] row_nxt;
	logic          col_wrap;
	logic          row_wrap;

	// Stage 1: pixel waiting for its line-buffer data
	logic                 v_s1;
	sss_pkg::pix_t        px_s1;
	logic [CW-1:0]        col_s1;
	logic                 emit_s1;
	sss_pkg::meta_t       meta_s1;

	// Stage 2: second half of the chain
	logic                 v_s2;
	sss_pkg::s2_t         s2_s2;

	// Window columns 1 and 2 (column 0 is dropped on every shift)
	sss_pkg::pix_t        win1_q [3];
	sss_pkg::pix_t        win2_q [3];

	// Handshake
	logic acc_in;
	logic fire_s1;
	logic fire_s2;
	logic rdy_s2;
	logic rdy_o;

	// Line buffers: [15:8] two rows above, [7:0] row above
	logic [sss_pkg::LB_W-1:0] lb_rdata;
	logic [sss_pkg::LB_W-1:0] lb_wdata;

	// Chain intermediates
	sss_pkg::pix_t v1;
	sss_pkg::pix_t v2;
	sss_pkg::pix_t v3;
	sss_pkg::pix_t v4;
	sss_pkg::pix_t w5;
	sss_pkg::pix_t w6;
	sss_pkg::pix_t w7;
	sss_pkg::pix_t w8;
	sss_pkg::pix_t ctr1;

	// Clamp the frame size
	always_comb begin
		if (width_q < WW'(3)) begin
			eff_w = WW'(3);
		end else if (width_q > sss_pkg::EFF_W_MAX) begin
			eff_w = sss_pkg::EFF_W_MAX;
		end else begin
			eff_w = width_q;
		end
		if (height_q < HW'(3)) begin
			eff_h = HW'(3);
		end else if (height_q > sss_pkg::EFF_H_MAX) begin
			eff_h = sss_pkg::EFF_H_MAX;
		end else begin
			eff_h = height_q;
		end
	end

	// Advance the raster position
	assign col_nxt  = WW'(col_q) + WW'(1);
	assign row_nxt  = HW'(row_q) + HW'(1);
	assign col_wrap = (col_nxt >= eff_w);
	assign row_wrap = (row_nxt >= eff_h);

	// Flow control through the three stages
	assign rdy_o         = !m_axis_tvalid || m_axis_tready;
	assign fire_s2       = v_s2 && rdy_o;
	assign rdy_s2        = !v_s2 || fire_s2;
	assign fire_s1       = v_s1 && (!emit_s1 || rdy_s2);
	assign s_axis_tready = !v_s1 || fire_s1;
	assign acc_in        = s_axis_tvalid && s_axis_tready;

	// Config registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sss_pkg::RST_WIDTH;
			height_q <= sss_pkg::RST_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wen) begin
			case (sss_pkg::cfg_reg_t'(cfg_addr))
				sss_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata[WW-1:0];
				end
				sss_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[HW-1:0];
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc_in) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_nxt[RW-1:0];
			end else begin
				col_q <= col_nxt[CW-1:0];
			end
		end
	end

	// Line-buffer RAM: read on accept, write back when the pixel leaves stage 1
	assign lb_wdata = {lb_rdata[PW-1:0], px_s1};

	sss_ram #(
		.WIDTH(sss_pkg::LB_W),
		.DEPTH(sss_pkg::MAX_WIDTH)
	) u_lb (
		.clk  (clk),
		.we   (fire_s1),
		.waddr(col_s1),
		.wdata(lb_wdata),
		.re   (acc_in),
		.raddr(col_q),
		.rdata(lb_rdata)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_s1         <= s_axis_tdata;
			col_s1        <= col_q;
			emit_s1       <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			meta_s1.row   <= row_q - RW'(1);
			meta_s1.col   <= col_q - CW'(1);
			meta_s1.last  <= (HW'(row_q) == eff_h - HW'(1)) && (WW'(col_q) == eff_w - WW'(1));
		end
	end

	// First half of the chain on the shifted window
	assign ctr1 = win2_q[1];
	assign v1   = sss_pkg::sharp_step(ctr1, win1_q[0], ctr1, 1'b1);
	assign v2   = sss_pkg::sharp_step(v1, win2_q[0], ctr1, 1'b1);
	assign v3   = sss_pkg::sharp_step(v2, lb_rdata[2*PW-1:PW], ctr1, 1'b1);
	assign v4   = sss_pkg::sharp_step(v3, win1_q[1], ctr1, 1'b1);

	// Shift the window when a pixel leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= '0;
				win2_q[i] <= '0;
			end
		end else if (fire_s1) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= win2_q[i];
			end
			win2_q[0] <= lb_rdata[2*PW-1:PW];
			win2_q[1] <= lb_rdata[PW-1:0];
			win2_q[2] <= px_s1;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= fire_s1 && emit_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			s2_s2.v     <= v4;
			s2_s2.ctr   <= ctr1;
			s2_s2.nb_r  <= lb_rdata[PW-1:0];
			s2_s2.nb_bl <= win1_q[2];
			s2_s2.nb_b  <= win2_q[2];
			s2_s2.nb_br <= px_s1;
			s2_s2.meta  <= meta_s1;
		end
	end

	// Second half of the chain; the last step has no add-back
	assign w5 = sss_pkg::sharp_step(s2_s2.v, s2_s2.nb_r, s2_s2.ctr, 1'b1);
	assign w6 = sss_pkg::sharp_step(w5, s2_s2.nb_bl, s2_s2.ctr, 1'b1);
	assign w7 = sss_pkg::sharp_step(w6, s2_s2.nb_b, s2_s2.ctr, 1'b1);
	assign w8 = sss_pkg::sharp_step(w7, s2_s2.nb_br, s2_s2.ctr, 1'b0);

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (rdy_o) begin
			m_axis_tvalid <= v_s2;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire_s2) begin
			m_axis_tdata <= {1'b0, s2_s2.meta.col, s2_s2.meta.row, w8};
			m_axis_tlast <= s2_s2.meta.last;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sss_checker.sv
// Port-level checker for the sharpen stencil core, bound to the top level.
// Uses the assertion macros header.
`default_nettype none
`include "saturating_3x3_sharpen_stencil_core_macros.svh"
module sss_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire        m_axis_tlast
);

	// Result beat holds while the sink stalls
	`SSS_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, {m_axis_tdata, m_axis_tlast})

	// Only interior pixels leave: row and column never on the top or left border
	`SSS_ASSERT_IMPLIES(a_row_interior, m_axis_tvalid, m_axis_tdata[19:8] != 12'd0)
	`SSS_ASSERT_IMPLIES(a_col_interior, m_axis_tvalid, m_axis_tdata[30:20] != 11'd0)

endmodule

bind saturating_3x3_sharpen_stencil_core sss_checker u_sss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
